### sv/sptw_pkg.sv
`timescale 1ns / 1ps
package sptw_pkg;

	localparam int ROT_FRAC_BITS = 14;

	localparam int POS_W     = 32;
	localparam int ROT_W     = 16;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;

	// q*q product, rotation pre-round sum, 16x32 product, position sum (3 or 4 terms)
	localparam int QPROD_W = 2 * ROT_W;
	localparam int RSUM_W  = QPROD_W + 4;
	localparam int PROD_W  = ROT_W + POS_W;
	localparam int PSUM_W  = PROD_W + 2;

	localparam logic [CFG_W-1:0] CAL_COL_A_RST = CFG_W'(1) << (ROT_W + ROT_FRAC_BITS);
	localparam logic [CFG_W-1:0] CAL_COL_B_RST = CFG_W'(1) << (2 * ROT_W + ROT_FRAC_BITS);

	typedef logic signed [ROT_W-1:0]  rot_t;
	typedef logic signed [POS_W-1:0]  pos_t;
	typedef rot_t [2:0]               rot_vec_t;
	typedef rot_vec_t [2:0]           rot_mat_t;   // [row][col]
	typedef pos_t [2:0]               pos_vec_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COL_A = 3'd0,
		CFG_COL_B = 3'd1,
		CFG_OFF_X = 3'd2,
		CFG_OFF_Y = 3'd3,
		CFG_OFF_Z = 3'd4
	} cfg_idx_t;

	// round half up by ROT_FRAC_BITS, saturate to a rotation entry
	function automatic rot_t rnd_sat_rot(input logic signed [RSUM_W-1:0] v);
		logic signed [RSUM_W-1:0] t;
		t = v + (RSUM_W'(1) << (ROT_FRAC_BITS - 1));
		t = t >>> ROT_FRAC_BITS;
		if ((&t[RSUM_W-1:ROT_W-1]) || !(|t[RSUM_W-1:ROT_W-1]))
			return t[ROT_W-1:0];
		else if (t[RSUM_W-1])
			return {1'b1, {(ROT_W-1){1'b0}}};
		else
			return {1'b0, {(ROT_W-1){1'b1}}};
	endfunction

	// round half up by ROT_FRAC_BITS, saturate to a position
	function automatic pos_t rnd_sat_pos(input logic signed [PSUM_W-1:0] v);
		logic signed [PSUM_W-1:0] t;
		t = v + (PSUM_W'(1) << (ROT_FRAC_BITS - 1));
		t = t >>> ROT_FRAC_BITS;
		if ((&t[PSUM_W-1:POS_W-1]) || !(|t[PSUM_W-1:POS_W-1]))
			return t[POS_W-1:0];
		else if (t[PSUM_W-1])
			return {1'b1, {(POS_W-1){1'b0}}};
		else
			return {1'b0, {(POS_W-1){1'b1}}};
	endfunction

	// position shifted up to the product scale, sign extended
	function automatic logic signed [PSUM_W-1:0] pos_scaled(input pos_t p);
		return {{(PSUM_W-POS_W-ROT_FRAC_BITS){p[POS_W-1]}}, p, {ROT_FRAC_BITS{1'b0}}};
	endfunction

endpackage

### sv/sptw_rot.sv
`timescale 1ns / 1ps
// Quaternion to rotation matrix: products in s1, sums/round/sat in s2.
module sptw_rot (
	input  logic               clk,
	input  sptw_pkg::rot_t     qx,
	input  sptw_pkg::rot_t     qy,
	input  sptw_pkg::rot_t     qz,
	input  sptw_pkg::rot_t     qw,
	output sptw_pkg::rot_mat_t rot_s2
);

	localparam int QW = sptw_pkg::QPROD_W;
	localparam int SW = sptw_pkg::RSUM_W;
	localparam logic signed [SW-1:0] ONE = SW'(1) << (2 * sptw_pkg::ROT_FRAC_BITS);

	logic signed [QW-1:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, xw_s1, yw_s1, zw_s1;

	always_ff @(posedge clk) begin
		xx_s1 <= qx * qx;
		yy_s1 <= qy * qy;
		zz_s1 <= qz * qz;
		xy_s1 <= qx * qy;
		xz_s1 <= qx * qz;
		yz_s1 <= qy * qz;
		xw_s1 <= qx * qw;
		yw_s1 <= qy * qw;
		zw_s1 <= qz * qw;
	end

	function automatic logic signed [SW-1:0] ext(input logic signed [QW-1:0] p);
		return {{(SW-QW){p[QW-1]}}, p};
	endfunction

	logic signed [SW-1:0] e [3][3];

	always_comb begin
		e[0][0] = ONE - ((ext(yy_s1) + ext(zz_s1)) <<< 1);
		e[0][1] = (ext(xy_s1) - ext(zw_s1)) <<< 1;
		e[0][2] = (ext(xz_s1) + ext(yw_s1)) <<< 1;
		e[1][0] = (ext(xy_s1) + ext(zw_s1)) <<< 1;
		e[1][1] = ONE - ((ext(xx_s1) + ext(zz_s1)) <<< 1);
		e[1][2] = (ext(yz_s1) - ext(xw_s1)) <<< 1;
		e[2][0] = (ext(xz_s1) - ext(yw_s1)) <<< 1;
		e[2][1] = (ext(yz_s1) + ext(xw_s1)) <<< 1;
		e[2][2] = ONE - ((ext(xx_s1) + ext(yy_s1)) <<< 1);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rot_s2[i][j] <= sptw_pkg::rnd_sat_rot(e[i][j]);
			end
		end
	end

endmodule

### sv/sptw_cal.sv
`timescale 1ns / 1ps
// Hand-eye calibration: col_a*a, col_b*b in s1, sum/round/sat in s2.
module sptw_cal (
	input  logic                            clk,
	input  logic [sptw_pkg::CFG_W-1:0]      col_a,
	input  logic [sptw_pkg::CFG_W-1:0]      col_b,
	input  sptw_pkg::pos_vec_t              off,
	input  sptw_pkg::pos_t                  a,
	input  sptw_pkg::pos_t                  b,
	output sptw_pkg::pos_vec_t              cal_s2
);

	localparam int RW = sptw_pkg::ROT_W;
	localparam int PW = sptw_pkg::PROD_W;
	localparam int SW = sptw_pkg::PSUM_W;

	logic signed [PW-1:0] pa_s1 [3];
	logic signed [PW-1:0] pb_s1 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pa_s1[i] <= $signed(col_a[RW*i +: RW]) * a;
			pb_s1[i] <= $signed(col_b[RW*i +: RW]) * b;
		end
	end

	logic signed [SW-1:0] sum [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = {{(SW-PW){pa_s1[i][PW-1]}}, pa_s1[i]}
			       + {{(SW-PW){pb_s1[i][PW-1]}}, pb_s1[i]}
			       + sptw_pkg::pos_scaled(off[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cal_s2[i] <= sptw_pkg::rnd_sat_pos(sum[i]);
		end
	end

endmodule

### sv/sptw_apply.sv
`timescale 1ns / 1ps
// Flange pose applied to the calibrated point: R*c in s3, sum/round/sat in s4.
module sptw_apply (
	input  logic               clk,
	input  sptw_pkg::rot_mat_t rot_s2,
	input  sptw_pkg::pos_vec_t cal_s2,
	input  sptw_pkg::pos_vec_t base_s2,
	output sptw_pkg::pos_vec_t world_s4
);

	localparam int PW = sptw_pkg::PROD_W;
	localparam int SW = sptw_pkg::PSUM_W;

	logic signed [PW-1:0] prod_s3 [3][3];
	sptw_pkg::pos_vec_t   base_s3;

	always_ff @(posedge clk) begin
		base_s3 <= base_s2;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s3[i][j] <= $signed(rot_s2[i][j]) * $signed(cal_s2[j]);
			end
		end
	end

	logic signed [SW-1:0] sum [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = {{(SW-PW){prod_s3[i][0][PW-1]}}, prod_s3[i][0]}
			       + {{(SW-PW){prod_s3[i][1][PW-1]}}, prod_s3[i][1]}
			       + {{(SW-PW){prod_s3[i][2][PW-1]}}, prod_s3[i][2]}
			       + sptw_pkg::pos_scaled($signed(base_s3[i]));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			world_s4[i] <= sptw_pkg::rnd_sat_pos(sum[i]);
		end
	end

endmodule

### sv/sensor_point_to_world_transform.sv
`timescale 1ns / 1ps
// Channel   Transfer when        Signals
// -------   -----------------    ------------------------------------------------
// command   start && !busy       base_x/y/z, quat_x/y/z/w, laser_a, laser_b
// result    done (one cycle)     world_x/y/z, out_qx/qy/qz/qw
// config    cfg_we               cfg_idx, cfg_wdata
//
// Four-stage pipeline: a command taken into s1 moves through s2 and s3 and
// is on the result ports with done high while it sits in s4, where it is
// taken; one transfer is taken every cycle. Each stage holds either a bank
// of 16x16/16x32 multiplies or one short sum with round and saturate.
// busy is held low. The receiver cannot stall, so the pipe never holds.
// arst_n clears the valid bits and loads the calibration reset values
// (identity columns, zero offset); data registers are not reset.
module sensor_point_to_world_transform (
	input  logic                                clk,
	input  logic                                arst_n,
	// command
	input  logic                                start,
	output logic                                busy,
	input  logic signed [sptw_pkg::POS_W-1:0]   base_x,
	input  logic signed [sptw_pkg::POS_W-1:0]   base_y,
	input  logic signed [sptw_pkg::POS_W-1:0]   base_z,
	input  logic signed [sptw_pkg::ROT_W-1:0]   quat_x,
	input  logic signed [sptw_pkg::ROT_W-1:0]   quat_y,
	input  logic signed [sptw_pkg::ROT_W-1:0]   quat_z,
	input  logic signed [sptw_pkg::ROT_W-1:0]   quat_w,
	input  logic signed [sptw_pkg::POS_W-1:0]   laser_a,
	input  logic signed [sptw_pkg::POS_W-1:0]   laser_b,
	// configuration
	input  logic                                cfg_we,
	input  logic [sptw_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [sptw_pkg::CFG_W-1:0]          cfg_wdata,
	// result
	output logic                                done,
	output logic signed [sptw_pkg::POS_W-1:0]   world_x,
	output logic signed [sptw_pkg::POS_W-1:0]   world_y,
	output logic signed [sptw_pkg::POS_W-1:0]   world_z,
	output logic signed [sptw_pkg::ROT_W-1:0]   out_qx,
	output logic signed [sptw_pkg::ROT_W-1:0]   out_qy,
	output logic signed [sptw_pkg::ROT_W-1:0]   out_qz,
	output logic signed [sptw_pkg::ROT_W-1:0]   out_qw
);

	localparam int PW = sptw_pkg::POS_W;

	// ---------------- calibration registers ----------------
	logic [sptw_pkg::CFG_W-1:0] cal_col_a_q;
	logic [sptw_pkg::CFG_W-1:0] cal_col_b_q;
	sptw_pkg::pos_vec_t         cal_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_col_a_q <= sptw_pkg::CAL_COL_A_RST;
			cal_col_b_q <= sptw_pkg::CAL_COL_B_RST;
			cal_off_q   <= '0;
		end else if (cfg_we) begin
			case (sptw_pkg::cfg_idx_t'(cfg_idx))
				sptw_pkg::CFG_COL_A: cal_col_a_q  <= cfg_wdata;
				sptw_pkg::CFG_COL_B: cal_col_b_q  <= cfg_wdata;
				sptw_pkg::CFG_OFF_X: cal_off_q[0] <= cfg_wdata[PW-1:0];
				sptw_pkg::CFG_OFF_Y: cal_off_q[1] <= cfg_wdata[PW-1:0];
				sptw_pkg::CFG_OFF_Z: cal_off_q[2] <= cfg_wdata[PW-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// ---------------- valid bits ----------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic take;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign done = v_s4;

	// ---------------- side-band data: base and quaternion ----------------
	sptw_pkg::pos_vec_t base_s1, base_s2;
	sptw_pkg::rot_t [3:0] q_s1, q_s2, q_s3, q_s4;

	always_ff @(posedge clk) begin
		base_s1 <= {base_z, base_y, base_x};
		base_s2 <= base_s1;
		q_s1    <= {quat_w, quat_z, quat_y, quat_x};
		q_s2    <= q_s1;
		q_s3    <= q_s2;
		q_s4    <= q_s3;
	end

	assign out_qx = q_s4[0];
	assign out_qy = q_s4[1];
	assign out_qz = q_s4[2];
	assign out_qw = q_s4[3];

	// ---------------- datapath ----------------
	sptw_pkg::rot_mat_t rot_s2;
	sptw_pkg::pos_vec_t cal_s2;
	sptw_pkg::pos_vec_t world_s4;

	// stages 1-2: rotation matrix from the flange quaternion
	sptw_rot u_rot (
		.clk    (clk),
		.qx     (quat_x),
		.qy     (quat_y),
		.qz     (quat_z),
		.qw     (quat_w),
		.rot_s2 (rot_s2)
	);

	// stages 1-2: sensor point (0, a, b) through the hand-eye transform
	sptw_cal u_cal (
		.clk    (clk),
		.col_a  (cal_col_a_q),
		.col_b  (cal_col_b_q),
		.off    (cal_off_q),
		.a      (laser_a),
		.b      (laser_b),
		.cal_s2 (cal_s2)
	);

	// stages 3-4: R * c + base, rounded and saturated
	sptw_apply u_apply (
		.clk      (clk),
		.rot_s2   (rot_s2),
		.cal_s2   (cal_s2),
		.base_s2  (base_s2),
		.world_s4 (world_s4)
	);

	assign world_x = world_s4[0];
	assign world_y = world_s4[1];
	assign world_z = world_s4[2];

endmodule
